/* rtl/core/tts_pkg.sv */
// Package for the tridiagonal solver: constants, status codes, command and
// status structs. No dependencies.
`default_nettype none
package tts_pkg;
  localparam int unsigned MaxRowsDefault  = 64;
  localparam int unsigned FracBitsDefault = 16;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZP   = 2'd1,
    STATUS_OV   = 2'd2,
    STATUS_RSVD = 2'd3
  } status_e;

  // datapath operations launched by the controller
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,  // latch row word
    OP_RATIO   = 3'd2,  // g = prev_super / pivot
    OP_PIVOT   = 3'd3,  // pivot = b - a*g
    OP_RHS     = 3'd4,  // t = r - a*p[i-1]
    OP_PART    = 3'd5,  // p[i] = t / pivot
    OP_BACK    = 3'd6,  // x = p[k] - g[k+1]*x
    OP_CLEAR   = 3'd7   // end of system
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;    // pulse: begin op
  } tts_cmd_t;

  typedef struct packed {
    logic done;     // pulse: op finished
    logic is_first; // row index zero
    logic is_final; // row ends the system
    logic k_zero;   // back-substitution index at row zero
  } tts_sts_t;
endpackage
`default_nettype wire

/* rtl/core/tts_if.sv */
// Valid/ready channel interfaces for the tridiagonal solver.
// Depends on nothing.
`default_nettype none
interface tts_row_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sub_diag;
  logic signed [31:0] main_diag;
  logic signed [31:0] super_diag;
  logic signed [31:0] rhs_value;
  logic               last_row;
  modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                  input ready);
  modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                output ready);
endinterface

interface tts_sol_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] solution;
  logic [5:0]         row_index;
  logic               last_result;
  logic [1:0]         status;
  modport source (output valid, solution, row_index, last_result, status, input ready);
  modport sink (input valid, solution, row_index, last_result, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/tridiagonal_thomas_solver.sv */
// Tridiagonal (Thomas) solver, signed Q(32-FRAC_BITS).FRAC_BITS.
// Per row: two serial divisions, one bit a cycle, plus two multiply-subtract
// steps; the first row of a system takes only the division p[0] = r / b.
// Back substitution: memory read, product and subtract for each result,
// then the output handshake.
// Reset (rst_ni low, async) returns to idle with an empty system; the row
// memories are not cleared and need none.
`default_nettype none
module tridiagonal_thomas_solver #(
  parameter int unsigned MAX_ROWS  = tts_pkg::MaxRowsDefault,
  parameter int unsigned FRAC_BITS = tts_pkg::FracBitsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tts_row_if.sink  row_i,
  tts_sol_if.source sol_o
);
  import tts_pkg::*;
  tts_cmd_t cmd;
  tts_sts_t sts;

  tts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(row_i.valid), .in_ready_o(row_i.ready),
    .out_valid_o(sol_o.valid), .out_ready_i(sol_o.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  tts_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sub_diag_i(row_i.sub_diag), .main_diag_i(row_i.main_diag),
    .super_diag_i(row_i.super_diag), .rhs_value_i(row_i.rhs_value),
    .last_row_i(row_i.last_row),
    .solution_o(sol_o.solution), .row_index_o(sol_o.row_index),
    .last_result_o(sol_o.last_result), .status_o(sol_o.status)
  );
endmodule
`default_nettype wire

/* rtl/core/tts_div.sv */
// Iterative signed divider: (num << FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on tts_pkg.
`default_nettype none
module tts_div #(
  parameter int unsigned FRAC_BITS = tts_pkg::FracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o,
  output logic                    zp_o,
  output logic                    ov_o
);
  import tts_pkg::*;
  localparam int unsigned NW = 32 + FRAC_BITS;   // dividend magnitude width
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [32:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d, busy_q, busy_d, zero_q, zero_d, nneg_q, nneg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [32:0]   trial;
  logic [NW:0]   mag;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; zero_d = zero_q; nneg_d = nneg_q; cnt_d = cnt_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d  = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      den_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d  = num_i[31] ^ den_i[31];
      nneg_d = num_i[31];
      zero_d = (den_i == 32'sd0);
      cnt_d  = CW'(NW);
      busy_d = (den_i != 32'sd0);
      done_d = (den_i == 32'sd0);
    end else if (busy_q) begin
      trial = {rem_q[31:0], quo_q[NW-1]} - {1'b0, den_q};
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
    neg_q <= neg_d; zero_q <= zero_d; nneg_q <= nneg_d;
  end

  assign mag = {1'b0, quo_q};
  always_comb begin
    zp_o = 1'b0;
    ov_o = 1'b0;
    if (zero_q) begin
      zp_o   = 1'b1;
      quot_o = nneg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!neg_q) begin
      if (mag > (NW+1)'(32'h7fff_ffff)) begin
        ov_o = 1'b1; quot_o = 32'sh7fff_ffff;
      end else quot_o = 32'(quo_q);
    end else begin
      if (mag > (NW+1)'(33'h0_8000_0000)) begin
        ov_o = 1'b1; quot_o = 32'sh8000_0000;
      end else quot_o = 32'(-quo_q);
    end
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

/* rtl/core/tts_datapath.sv */
// Datapath: row registers, ratio/partial memories, multiplier, divider,
// output register. Depends on tts_pkg and tts_div.
`default_nettype none
module tts_datapath #(
  parameter int unsigned MAX_ROWS  = tts_pkg::MaxRowsDefault,
  parameter int unsigned FRAC_BITS = tts_pkg::FracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tts_pkg::tts_cmd_t  cmd_i,
  output tts_pkg::tts_sts_t       sts_o,
  input  wire logic signed [31:0] sub_diag_i,
  input  wire logic signed [31:0] main_diag_i,
  input  wire logic signed [31:0] super_diag_i,
  input  wire logic signed [31:0] rhs_value_i,
  input  wire logic               last_row_i,
  output logic signed [31:0]      solution_o,
  output logic [5:0]              row_index_o,
  output logic                    last_result_o,
  output logic [1:0]              status_o
);
  import tts_pkg::*;
  localparam int unsigned AW = $clog2(MAX_ROWS);

  logic signed [31:0] ratio_mem [MAX_ROWS];
  logic signed [31:0] part_mem  [MAX_ROWS];
  logic signed [31:0] a_q, b_q, r_q, c_q, g_q, t_q, x_q, pivot_q, prev_q;
  logic signed [31:0] rd_ratio_q, rd_part_q, p_prev_q;
  logic               last_q;
  logic [AW-1:0]      row_q, k_q;
  logic [1:0]         flags_q;
  logic [1:0]         phase_q;   // multiply and back-sub sub-steps

  // multiplier, shared
  logic signed [31:0] mul_x, mul_y, mul_res;
  logic signed [63:0] prod;
  logic signed [64:0] prod_r;
  logic signed [64:0] sh;
  logic               mul_ov;
  always_comb begin
    mul_x = a_q; mul_y = g_q;
    if (cmd_i.op == OP_RHS) mul_y = p_prev_q;
    else if (cmd_i.op == OP_BACK) begin mul_x = rd_ratio_q; mul_y = x_q; end
    prod   = 64'(mul_x) * 64'(mul_y);
    prod_r = 65'(prod) + 65'(65'sd1 <<< (FRAC_BITS - 1));
    sh     = prod_r >>> FRAC_BITS;
    mul_ov = (sh > 65'sd2147483647) || (sh < -65'sd2147483648);
    mul_res = (sh > 65'sd2147483647) ? 32'sh7fff_ffff :
              (sh < -65'sd2147483648) ? 32'sh8000_0000 : 32'(sh);
  end

  // registered product, then subtract
  logic signed [31:0] m_q, sub_lhs;
  logic signed [32:0] diff;
  logic signed [31:0] diff_sat;
  logic               diff_ov;
  always_comb begin
    sub_lhs = b_q;
    if (cmd_i.op == OP_RHS) sub_lhs = r_q;
    else if (cmd_i.op == OP_BACK) sub_lhs = rd_part_q;
    diff     = 33'(sub_lhs) - 33'(m_q);
    diff_ov  = (diff[32] != diff[31]);
    diff_sat = diff_ov ? (diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : diff[31:0];
  end

  // divider
  logic               div_start, div_done, div_zp, div_ov;
  logic signed [31:0] div_num, div_den, div_q;
  assign div_num = (cmd_i.op == OP_RATIO) ? prev_q : t_q;
  assign div_den = pivot_q;
  assign div_start = cmd_i.start && (cmd_i.op == OP_RATIO || cmd_i.op == OP_PART);
  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q), .zp_o(div_zp), .ov_o(div_ov)
  );

  // mul ops: phase 0 product, phase 1 subtract
  logic mul_busy_q, done_q;
  logic rd_busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0; done_q <= 1'b0; rd_busy_q <= 1'b0; phase_q <= '0;
      flags_q <= '0; row_q <= '0; k_q <= '0; pivot_q <= '0; prev_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        unique case (cmd_i.op)
          OP_LOAD: begin
            done_q <= 1'b1;
          end
          OP_PIVOT, OP_RHS: begin
            mul_busy_q <= 1'b1; phase_q <= 2'd0;
          end
          OP_BACK: begin
            rd_busy_q <= 1'b1; phase_q <= 2'd0;
          end
          OP_CLEAR: begin
            flags_q <= '0; row_q <= '0; pivot_q <= '0; prev_q <= '0;
            done_q <= 1'b1;
          end
          default: ;
        endcase
        if (cmd_i.op == OP_LOAD && row_q == '0) pivot_q <= main_diag_i;
      end else if (mul_busy_q) begin
        if (phase_q == 2'd0) begin
          phase_q <= 2'd1;
          if (mul_ov) flags_q[1] <= 1'b1;
        end else begin
          mul_busy_q <= 1'b0; done_q <= 1'b1;
          if (diff_ov) flags_q[1] <= 1'b1;
          if (cmd_i.op == OP_PIVOT) pivot_q <= diff_sat;
        end
      end else if (rd_busy_q) begin
        // phase 0: memory read; 1: product; 2: subtract
        if (phase_q == 2'd0) phase_q <= 2'd1;
        else if (phase_q == 2'd1) begin
          phase_q <= 2'd2;
          if (k_q != row_q && mul_ov) flags_q[1] <= 1'b1;
        end else begin
          rd_busy_q <= 1'b0; done_q <= 1'b1;
          if (k_q != row_q && diff_ov) flags_q[1] <= 1'b1;
        end
      end
      if (div_done) begin
        done_q <= 1'b1;
        flags_q <= flags_q | {div_ov, div_zp};
      end
      if (done_q && cmd_i.op == OP_PART) begin
        prev_q <= c_q;
        if (row_q != AW'(MAX_ROWS - 1) && !last_q) row_q <= row_q + AW'(1);
        else k_q <= row_q;
      end
      if (done_q && cmd_i.op == OP_BACK) k_q <= k_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && cmd_i.op == OP_LOAD) begin
      a_q <= sub_diag_i; b_q <= main_diag_i; c_q <= super_diag_i;
      r_q <= rhs_value_i; last_q <= last_row_i;
      t_q <= rhs_value_i;
    end
    if (mul_busy_q || rd_busy_q) m_q <= mul_res;
    if (mul_busy_q && phase_q == 2'd1 && cmd_i.op == OP_RHS) t_q <= diff_sat;
    if (div_done && cmd_i.op == OP_RATIO) g_q <= div_q;
    if (div_done && cmd_i.op == OP_RATIO) ratio_mem[row_q] <= div_q;
    if (div_done && cmd_i.op == OP_PART) begin
      part_mem[row_q] <= div_q;
      p_prev_q <= div_q;
    end
    if (rd_busy_q && phase_q == 2'd0) begin
      rd_part_q  <= part_mem[k_q];
      rd_ratio_q <= ratio_mem[(k_q == row_q) ? k_q : k_q + AW'(1)];
    end
    if (rd_busy_q && phase_q == 2'd2) begin
      x_q <= (k_q == row_q) ? rd_part_q : diff_sat;
      solution_o    <= (k_q == row_q) ? rd_part_q : diff_sat;
      row_index_o   <= 6'(k_q);
      last_result_o <= (k_q == '0);
    end
  end

  // status as seen after this result's flags settle
  logic [1:0] fl_now;
  assign fl_now = flags_q;
  assign status_o = fl_now[0] ? STATUS_ZP : (fl_now[1] ? STATUS_OV : STATUS_OK);

  assign sts_o.done     = done_q;
  assign sts_o.is_first = (row_q == '0);
  assign sts_o.is_final = last_q || (row_q == AW'(MAX_ROWS - 1));
  assign sts_o.k_zero   = (k_q == '0);
endmodule
`default_nettype wire

/* rtl/core/tts_ctrl.sv */
// Controller FSM sequencing elimination, back substitution and handshakes.
// Depends on tts_pkg.
`default_nettype none
module tts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tts_pkg::tts_cmd_t      cmd_o,
  input  wire tts_pkg::tts_sts_t sts_i
);
  import tts_pkg::*;
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_RATIO = 8'b0000_0100,
    S_PIVOT = 8'b0000_1000,
    S_RHS   = 8'b0001_0000,
    S_PART  = 8'b0010_0000,
    S_BACK  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   go_q, go_d;   // start pulse for state's op
  logic   fin_q, fin_d;

  always_comb begin
    state_d = state_q; go_d = 1'b0; fin_d = fin_q;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    cmd_o.op = OP_NONE; cmd_o.start = go_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1; cmd_o.op = OP_LOAD;
        cmd_o.start = in_valid_i;
        if (in_valid_i) state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD; cmd_o.start = 1'b0;
        go_d = 1'b1;
        state_d = sts_i.is_first ? S_PART : S_RATIO;
      end
      S_RATIO: begin
        cmd_o.op = OP_RATIO;
        if (sts_i.done) begin go_d = 1'b1; state_d = S_PIVOT; end
      end
      S_PIVOT: begin
        cmd_o.op = OP_PIVOT;
        if (sts_i.done) begin go_d = 1'b1; state_d = S_RHS; end
      end
      S_RHS: begin
        cmd_o.op = OP_RHS;
        if (sts_i.done) begin go_d = 1'b1; state_d = S_PART; end
      end
      S_PART: begin
        cmd_o.op = OP_PART;
        if (sts_i.done) begin
          if (sts_i.is_final) begin go_d = 1'b1; state_d = S_BACK; end
          else state_d = S_IDLE;
        end
      end
      S_BACK: begin
        cmd_o.op = OP_BACK;
        if (sts_i.done) begin
          fin_d = sts_i.k_zero;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.op = OP_NONE; out_valid_o = 1'b1;
        if (out_ready_i) begin
          go_d = 1'b1;
          state_d = S_BACK;
          if (fin_q) begin cmd_o.op = OP_CLEAR; cmd_o.start = 1'b1; state_d = S_IDLE;
            go_d = 1'b0; end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; go_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d; go_q <= go_d; fin_q <= fin_d;
    end
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for tridiagonal_thomas_solver: directed rows, then random systems,
// each result compared with a built-in Thomas solver model.
// Depends on tts_pkg, the tts_row_if / tts_sol_if interfaces and tridiagonal_thomas_solver of the RTL.
module tb_top;
  import tts_pkg::*;

  localparam int unsigned NROWS = 64;
  localparam int unsigned FRACB = 16;
  localparam int          IDLE_LIMIT = 20000;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;
  localparam logic [1:0] FLG_ZP = 2'b01;
  localparam logic [1:0] FLG_OV = 2'b10;

  typedef struct {
    logic signed [31:0] a, b, c, r;
    logic               last;
    logic               typed;
    logic signed [31:0] x_exp;
    status_e            st_exp;
  } row_t;

  typedef struct {
    logic signed [31:0] x;
    logic [5:0]         idx;
    logic               fin;
    status_e            st;
  } sol_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  tts_row_if row_if ();
  tts_sol_if sol_if ();

  tridiagonal_thomas_solver uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .row_i  (row_if.sink),
    .sol_o  (sol_if.source)
  );

  // solver model state
  logic signed [31:0] ratio_m [NROWS];
  logic signed [31:0] part_m  [NROWS];
  logic signed [31:0] pivot_m, prev_super_m;
  int unsigned        row_cnt_m;
  logic [1:0]         flags_m;

  sol_t solutions_q[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_tok = 0;
  int   idle_cycles = 0;
  logic timed_out = 1'b0;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(QMAX)) begin
      flags_m |= FLG_OV;
      return QMAX;
    end
    if (v < 64'(QMIN)) begin
      flags_m |= FLG_OV;
      return QMIN;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties up, then floor shift
  function automatic logic signed [31:0] qmul(input logic signed [31:0] x, y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y) + (64'sd1 <<< (FRACB - 1));
    return sat32(p >>> FRACB);
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] num, den);
    logic signed [63:0] n;
    if (den == 0) begin
      flags_m |= FLG_ZP;
      return (num < 0) ? QMIN : QMAX;
    end
    n = 64'(num) <<< FRACB;
    return sat32(n / 64'(den));
  endfunction

  function automatic status_e flag_status();
    if (flags_m & FLG_ZP) return STATUS_ZP;
    if (flags_m & FLG_OV) return STATUS_OV;
    return STATUS_OK;
  endfunction

  task automatic eliminate_row(input row_t rw);
    int unsigned i;
    int unsigned n;
    logic signed [31:0] g, x;
    sol_t s;
    i = (row_cnt_m >= NROWS) ? NROWS - 1 : row_cnt_m;
    if (i == 0) begin
      pivot_m = rw.b;
      part_m[0] = qdiv(rw.r, pivot_m);
    end else begin
      g = qdiv(prev_super_m, pivot_m);
      ratio_m[i] = g;
      pivot_m = sat32(64'(rw.b) - 64'(qmul(rw.a, g)));
      part_m[i] = qdiv(sat32(64'(rw.r) - 64'(qmul(rw.a, part_m[i-1]))), pivot_m);
    end
    prev_super_m = rw.c;
    if (!rw.last && i < NROWS - 1) begin
      row_cnt_m = i + 1;
      return;
    end
    n = i + 1;
    x = '0;
    for (int k = n - 1; k >= 0; k--) begin
      if (k == n - 1) x = part_m[k];
      else x = sat32(64'(part_m[k]) - 64'(qmul(ratio_m[k+1], x)));
      s.x   = x;
      s.idx = 6'(k);
      s.fin = (k == 0);
      s.st  = flag_status();
      if (rw.typed && k == 0) begin
        s.x  = rw.x_exp;
        s.st = rw.st_exp;
      end
      solutions_q.push_back(s);
    end
    row_cnt_m = 0;
    pivot_m = '0;
    prev_super_m = '0;
    flags_m = '0;
  endtask

  task automatic offer_row(input row_t rw);
    while ($urandom_range(99) < idle_pct) begin
      row_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    row_if.valid      <= 1'b1;
    row_if.sub_diag   <= rw.a;
    row_if.main_diag  <= rw.b;
    row_if.super_diag <= rw.c;
    row_if.rhs_value  <= rw.r;
    row_if.last_row   <= rw.last;
    do @(posedge clk_i); while (!row_if.ready);
    eliminate_row(rw);
  endtask

  function automatic row_t plain_row(input logic signed [31:0] a, b, c, r, input logic last);
    row_t rw;
    rw = '{a: a, b: b, c: c, r: r, last: last, typed: 1'b0, x_exp: '0, st_exp: STATUS_OK};
    return rw;
  endfunction

  function automatic row_t typed_row(input logic signed [31:0] b, r, x,
                                     input status_e st);
    row_t rw;
    rw = '{a: QMIN, b: b, c: QMAX, r: r, last: 1'b1, typed: 1'b1, x_exp: x, st_exp: st};
    return rw;
  endfunction

  // diagonally dominant row (now and then with a zero main diagonal), or pure noise
  function automatic row_t random_row(input logic last, input int noise_pct);
    row_t rw;
    if ($urandom_range(99) < noise_pct)
      return plain_row($urandom, $urandom, $urandom, $urandom, last);
    rw = plain_row($signed($urandom_range(131072)) - 65536,
                   ($urandom_range(1) ? 1 : -1) * $signed($urandom_range(3200000, 140000)),
                   $signed($urandom_range(131072)) - 65536,
                   $signed($urandom_range(2097152)) - 1048576, last);
    if ($urandom_range(19) == 0) rw.b = '0;
    return rw;
  endfunction

  row_t directed_tbl[] = '{
    typed_row(ONE, 32'sh00020000, 32'sh00020000, STATUS_OK),
    typed_row(32'sh0, 32'sd5, QMAX, STATUS_ZP),
    typed_row(32'sh0, -32'sd1, QMIN, STATUS_ZP),
    typed_row(32'sh0, 32'sh0, QMAX, STATUS_ZP),
    typed_row(32'sd1, QMAX, QMAX, STATUS_OV),
    typed_row(-32'sd1, QMAX, QMIN, STATUS_OV),
    typed_row(QMIN, QMIN, ONE, STATUS_OK),
    plain_row(QMAX, QMAX, QMIN, QMIN, 1'b0),
    plain_row(QMIN, QMIN, QMAX, QMAX, 1'b0),
    plain_row(32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1),
    plain_row(32'sh0, 32'sh40000, ONE, ONE, 1'b0),
    plain_row(ONE, 32'sh40000, ONE, 32'sh20000, 1'b0),
    plain_row(ONE, 32'sh40000, QMAX, -32'sh30000, 1'b1),
    plain_row(QMAX, ONE, ONE, ONE, 1'b0),
    plain_row(ONE, ONE, ONE, ONE, 1'b1),
    plain_row(-32'sd1, 32'sh7fff0000, 32'sd1, QMAX, 1'b0),
    plain_row(32'sh12345678, -32'sh7fff0000, 32'sd0, QMIN, 1'b1)
  };

  // receiver: random stall, plus a long hold when the sender asks for one;
  // the hold outlasts a whole system so the input backs up behind it
  always @(posedge clk_i) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_tok != hold_seen) begin
      hold_seen = hold_tok;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      sol_if.ready <= 1'b0;
    end else begin
      sol_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    sol_t e;
    if (rst_ni) begin
      if ((row_if.valid && row_if.ready) || (sol_if.valid && sol_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (sol_if.valid && sol_if.ready) begin
        if (solutions_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: x=%h row=%0d", sol_if.solution, sol_if.row_index);
        end else begin
          e = solutions_q.pop_front();
          if (sol_if.solution !== e.x || sol_if.row_index !== e.idx ||
              sol_if.last_result !== e.fin || sol_if.status !== e.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp x=%h row=%0d last=%b st=%0d, ",
                        "got x=%h row=%0d last=%b st=%0d"},
                       e.x, e.idx, e.fin, e.st, sol_if.solution, sol_if.row_index,
                       sol_if.last_result, sol_if.status);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (timed_out) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int items;
    int len;
    int ph;
    row_if.valid      = 1'b0;
    row_if.sub_diag   = '0;
    row_if.main_diag  = '0;
    row_if.super_diag = '0;
    row_if.rhs_value  = '0;
    row_if.last_row   = 1'b0;
    sol_if.ready      = 1'b0;
    row_cnt_m = 0;
    pivot_m = '0;
    prev_super_m = '0;
    flags_m = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[j]) offer_row(directed_tbl[j]);
    items = directed_tbl.size();

    // full-depth system: last row forced by the row limit
    for (int j = 0; j < NROWS; j++) offer_row(random_row(1'b0, 0));
    items += NROWS;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int s = 0; s < 5; s++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
        if (ph == 2 && s == 1) hold_tok <= hold_tok + 1;
        for (int j = 0; j < len; j++) offer_row(random_row(j == len - 1, 15));
        items += len;
        if (ph == 1 && s == 2) begin
          row_if.valid <= 1'b0;
          while (solutions_q.size() != 0) @(posedge clk_i);
        end
      end
    end
    // top up to the intended item count
    while (items < 160) begin
      len = $urandom_range(6, 1);
      for (int j = 0; j < len; j++) offer_row(random_row(j == len - 1, 15));
      items += len;
    end
    row_if.valid <= 1'b0;
    stall_pct = 0;
    while (solutions_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && solutions_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
